// ----- src/ctsc_pkg.sv -----
`default_nettype none
package ctsc_pkg;

  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned HOUR_MAX      = 23;
  localparam int unsigned MINUTE_MAX    = 59;
  localparam int unsigned TIMEOUT_RESET = 30000;

  // floor(2^32 / divisor); the quotient comes out at most one low
  localparam logic [20:0] RECIP_HOUR = 21'd1193046;
  localparam logic [27:0] RECIP_DAY  = 28'd178956970;
  // ceil(2^18 / 60), exact for values below one hour of seconds
  localparam logic [12:0] RECIP_MIN  = 13'd4370;
  localparam int unsigned MIN_SHIFT  = 18;

  localparam logic [3:0] ST_ENTER_WORK = 4'd0;
  localparam logic [3:0] ST_WORK       = 4'd1;
  localparam logic [3:0] ST_ENTER_HOUR = 4'd2;
  localparam logic [3:0] ST_HOUR       = 4'd3;
  localparam logic [3:0] ST_ENTER_MIN  = 4'd4;
  localparam logic [3:0] ST_MIN        = 4'd5;
  localparam logic [3:0] ST_INC_HOUR   = 4'd6;
  localparam logic [3:0] ST_DEC_HOUR   = 4'd7;
  localparam logic [3:0] ST_INC_MIN    = 4'd8;
  localparam logic [3:0] ST_DEC_MIN    = 4'd9;
  localparam logic [3:0] ST_UPDATE     = 4'd10;
  localparam logic [3:0] ST_CANCEL     = 4'd11;

  localparam int unsigned PEND_SET  = 0;
  localparam int unsigned PEND_UP   = 1;
  localparam int unsigned PEND_DOWN = 2;

  localparam logic [1:0] CURSOR_NONE   = 2'd0;
  localparam logic [1:0] CURSOR_HOUR   = 2'd1;
  localparam logic [1:0] CURSOR_MINUTE = 2'd2;

  typedef struct packed {
    logic set_press;
    logic up_press;
    logic down_press;
    logic long_set_press;
  } btn_t;

  typedef struct packed {
    logic [31:0] now_ticks;
    logic [31:0] rtc_seconds;
    btn_t        btn;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } item_t;

endpackage
`default_nettype wire

// ----- src/ctsc_split.sv -----
`default_nettype none
module ctsc_split (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [31:0]     now_ticks,
  input  wire logic [31:0]     rtc_seconds,
  input  wire ctsc_pkg::btn_t  btn,
  output logic                 item_valid,
  input  wire logic            item_ready,
  output ctsc_pkg::item_t      item
);
  import ctsc_pkg::*;

  // stage 1: input register
  logic        s1_valid;
  logic [31:0] s1_now;
  logic [31:0] s1_rtc;
  btn_t        s1_btn;
  logic [52:0] s1_prod;

  // stage 2: rtc / 3600 estimate
  logic        s2_valid;
  logic [31:0] s2_now;
  logic [31:0] s2_rtc;
  btn_t        s2_btn;
  logic [52:0] s2_prod;
  logic [20:0] s2_q_est;
  logic [32:0] s2_rem_est;
  logic        s2_fix;
  logic [20:0] s2_hours;
  logic [11:0] s2_rem;

  // stage 3: hours and seconds within the hour
  logic        s3_valid;
  logic [31:0] s3_now;
  logic [31:0] s3_rtc;
  btn_t        s3_btn;
  logic [20:0] s3_hours;
  logic [11:0] s3_rem;
  logic [48:0] s3_prod_day;
  logic [24:0] s3_prod_min;

  // stage 4: hour of day and minute
  logic        s4_valid;
  logic [31:0] s4_now;
  logic [31:0] s4_rtc;
  btn_t        s4_btn;
  logic [20:0] s4_hours;
  logic [48:0] s4_prod_day;
  logic [24:0] s4_prod_min;
  logic [16:0] s4_q_est;
  logic [21:0] s4_hr_est;
  logic [4:0]  s4_hour;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic s4_ready;

  assign s4_ready = !s4_valid || item_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
    end
  end

  assign s1_prod = 53'(s1_rtc) * 53'(RECIP_HOUR);

  assign s2_q_est   = s2_prod[52:32];
  assign s2_rem_est = {1'b0, s2_rtc} - 33'(s2_q_est) * 33'(SEC_PER_HOUR);
  assign s2_fix     = (s2_rem_est >= 33'(SEC_PER_HOUR));
  assign s2_hours   = s2_q_est + 21'(s2_fix);
  assign s2_rem     = s2_fix ? 12'(s2_rem_est - 33'(SEC_PER_HOUR)) : 12'(s2_rem_est);

  assign s3_prod_day = 49'(s3_hours) * 49'(RECIP_DAY);
  assign s3_prod_min = 25'(s3_rem) * 25'(RECIP_MIN);

  assign s4_q_est  = s4_prod_day[48:32];
  assign s4_hr_est = 22'(s4_hours) - 22'(s4_q_est) * 22'(HOURS_PER_DAY);
  assign s4_hour   = (s4_hr_est >= 22'(HOURS_PER_DAY)) ?
                     5'(s4_hr_est - 22'(HOURS_PER_DAY)) : 5'(s4_hr_est);

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_now <= now_ticks;
      s1_rtc <= rtc_seconds;
      s1_btn <= btn;
    end
    if (s2_ready) begin
      s2_now  <= s1_now;
      s2_rtc  <= s1_rtc;
      s2_btn  <= s1_btn;
      s2_prod <= s1_prod;
    end
    if (s3_ready) begin
      s3_now   <= s2_now;
      s3_rtc   <= s2_rtc;
      s3_btn   <= s2_btn;
      s3_hours <= s2_hours;
      s3_rem   <= s2_rem;
    end
    if (s4_ready) begin
      s4_now      <= s3_now;
      s4_rtc      <= s3_rtc;
      s4_btn      <= s3_btn;
      s4_hours    <= s3_hours;
      s4_prod_day <= s3_prod_day;
      s4_prod_min <= s3_prod_min;
    end
  end

  assign item_valid       = s4_valid;
  assign item.now_ticks   = s4_now;
  assign item.rtc_seconds = s4_rtc;
  assign item.btn         = s4_btn;
  assign item.hour        = s4_hour;
  assign item.minute      = s4_prod_min[MIN_SHIFT+5:MIN_SHIFT];

endmodule
`default_nettype wire

// ----- src/ctsc_ctrl.sv -----
`default_nettype none
module ctsc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [31:0]      cfg_data,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire ctsc_pkg::item_t  item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  setup_mode,
  output logic                  blink,
  output logic                  display_update,
  output logic [31:0]           display_seconds,
  output logic [1:0]            cursor_field,
  output logic                  write_time,
  output logic [16:0]           write_seconds
);
  import ctsc_pkg::*;

  logic [31:0] timeout_ticks;
  logic [3:0]  state;
  logic [31:0] edit_start;
  logic [31:0] last_shown;
  logic [4:0]  edit_hour;
  logic [5:0]  edit_minute;
  logic [2:0]  pend_short;
  logic        pend_long;
  logic        setup_bit;

  logic [3:0]  state_next;
  logic [31:0] edit_start_next;
  logic [31:0] last_shown_next;
  logic [4:0]  edit_hour_next;
  logic [5:0]  edit_minute_next;
  logic [2:0]  pend_short_next;
  logic        pend_long_next;
  logic        setup_bit_next;
  logic        upd_next;
  logic [31:0] disp_next;
  logic [1:0]  cursor_next;
  logic        wr_next;
  logic [16:0] wr_val_next;

  logic [3:0]  cur;
  logic [16:0] edit_value;
  logic [31:0] elapsed;
  logic        timed_out;
  logic        fire;

  assign cfg_ready  = 1'b1;
  assign item_ready = !out_valid || out_ready;
  assign fire       = item_valid && item_ready;

  assign cur        = (state > ST_CANCEL) ? ST_ENTER_WORK : state;
  assign edit_value = 17'(edit_hour) * 17'(SEC_PER_HOUR) + 17'(edit_minute) * 17'(SEC_PER_MIN);
  assign elapsed    = item.now_ticks - edit_start;
  assign timed_out  = (elapsed >= timeout_ticks);

  always_comb begin
    pend_short_next = pend_short |
                      {item.btn.down_press, item.btn.up_press, item.btn.set_press};
    pend_long_next  = pend_long | item.btn.long_set_press;
    state_next       = cur;
    edit_start_next  = edit_start;
    last_shown_next  = last_shown;
    edit_hour_next   = edit_hour;
    edit_minute_next = edit_minute;
    setup_bit_next   = setup_bit;
    upd_next         = 1'b0;
    disp_next        = '0;
    cursor_next      = CURSOR_NONE;
    wr_next          = 1'b0;
    wr_val_next      = '0;

    case (cur)
      ST_ENTER_WORK, ST_WORK: begin
        setup_bit_next = 1'b0;
        state_next     = ST_WORK;
        if (item.rtc_seconds != last_shown) begin
          upd_next        = 1'b1;
          disp_next       = item.rtc_seconds;
          last_shown_next = item.rtc_seconds;
        end
        if (pend_long_next) begin
          edit_hour_next   = item.hour;
          edit_minute_next = item.minute;
          pend_long_next   = 1'b0;
          pend_short_next  = '0;
          state_next       = ST_ENTER_HOUR;
        end
      end
      ST_ENTER_HOUR: begin
        setup_bit_next  = 1'b1;
        upd_next        = 1'b1;
        disp_next       = 32'(edit_value);
        cursor_next     = CURSOR_HOUR;
        edit_start_next = item.now_ticks;
        state_next      = ST_HOUR;
      end
      ST_ENTER_MIN: begin
        upd_next        = 1'b1;
        disp_next       = 32'(edit_value);
        cursor_next     = CURSOR_MINUTE;
        edit_start_next = item.now_ticks;
        state_next      = ST_MIN;
      end
      ST_HOUR, ST_MIN: begin
        // a pending button beats the timeout
        if (timed_out) state_next = ST_CANCEL;
        if (pend_short_next[PEND_SET]) begin
          pend_short_next[PEND_SET] = 1'b0;
          state_next = (cur == ST_HOUR) ? ST_ENTER_MIN : ST_UPDATE;
        end else if (pend_short_next[PEND_UP]) begin
          pend_short_next[PEND_UP] = 1'b0;
          state_next = (cur == ST_HOUR) ? ST_INC_HOUR : ST_INC_MIN;
        end else if (pend_short_next[PEND_DOWN]) begin
          pend_short_next[PEND_DOWN] = 1'b0;
          state_next = (cur == ST_HOUR) ? ST_DEC_HOUR : ST_DEC_MIN;
        end
      end
      ST_INC_HOUR: begin
        edit_hour_next = (edit_hour >= 5'(HOUR_MAX)) ? 5'd0 : edit_hour + 5'd1;
        state_next     = ST_ENTER_HOUR;
      end
      ST_DEC_HOUR: begin
        edit_hour_next = (edit_hour == 5'd0 || edit_hour > 5'(HOUR_MAX)) ?
                         5'(HOUR_MAX) : edit_hour - 5'd1;
        state_next     = ST_ENTER_HOUR;
      end
      ST_INC_MIN: begin
        edit_minute_next = (edit_minute >= 6'(MINUTE_MAX)) ? 6'd0 : edit_minute + 6'd1;
        state_next       = ST_ENTER_MIN;
      end
      ST_DEC_MIN: begin
        edit_minute_next = (edit_minute == 6'd0 || edit_minute > 6'(MINUTE_MAX)) ?
                           6'(MINUTE_MAX) : edit_minute - 6'd1;
        state_next       = ST_ENTER_MIN;
      end
      ST_UPDATE: begin
        wr_next     = 1'b1;
        wr_val_next = edit_value;
        state_next  = ST_ENTER_WORK;
      end
      default: begin
        state_next = ST_ENTER_WORK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 32'(TIMEOUT_RESET);
      state         <= ST_ENTER_WORK;
      edit_start    <= '0;
      last_shown    <= '0;
      edit_hour     <= '0;
      edit_minute   <= '0;
      pend_short    <= '0;
      pend_long     <= 1'b0;
      setup_bit     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_ticks <= cfg_data;
      if (item_ready) out_valid <= item_valid;
      if (fire) begin
        state       <= state_next;
        edit_start  <= edit_start_next;
        last_shown  <= last_shown_next;
        edit_hour   <= edit_hour_next;
        edit_minute <= edit_minute_next;
        pend_short  <= pend_short_next;
        pend_long   <= pend_long_next;
        setup_bit   <= setup_bit_next;
      end
    end
  end

  // result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (fire) begin
      setup_mode      <= setup_bit_next;
      blink           <= setup_bit_next;
      display_update  <= upd_next;
      display_seconds <= disp_next;
      cursor_field    <= cursor_next;
      write_time      <= wr_next;
      write_seconds   <= wr_val_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/clock_time_set_controller.sv -----
// Time-set controller for a seconds-count clock driven by three buttons.
// Input channel (in_valid/in_ready): one item per task-loop pass with the
// tick count, the clock value in seconds and the SET/UP/DOWN/long-SET events.
// Output channel (out_valid/out_ready): exactly one result per item, in order:
// setup/blink flags, an optional display value with cursor field, and an
// optional clock load request with the new value.
// Config channel (cfg_valid/cfg_ready/cfg_data): the edit timeout in ticks;
// always ready, write it only while no items are in flight.
// Four registered stages split the clock value into hour of day and minute
// by reciprocal multiplication, then the control step runs and loads the
// result register.
// Throughput: one item per cycle while out_ready does not stall the output.
// Reset: controller returns to the enter-work state, pending events and the
// edit fields clear, the timeout returns to 30000 ticks, pipeline empties.
// Stall: a result waits in the output register; earlier stages keep filling
// until every stage is occupied, then in_ready drops.
`default_nettype none
module clock_time_set_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] now_ticks,
  input  wire logic [31:0] rtc_seconds,
  input  wire logic        set_press,
  input  wire logic        up_press,
  input  wire logic        down_press,
  input  wire logic        long_set_press,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             setup_mode,
  output logic             blink,
  output logic             display_update,
  output logic [31:0]      display_seconds,
  output logic [1:0]       cursor_field,
  output logic             write_time,
  output logic [16:0]      write_seconds
);
  import ctsc_pkg::*;

  btn_t  btn;
  item_t item;
  logic  item_valid;
  logic  item_ready;

  assign btn.set_press      = set_press;
  assign btn.up_press       = up_press;
  assign btn.down_press     = down_press;
  assign btn.long_set_press = long_set_press;

  ctsc_split u_split (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .now_ticks   (now_ticks),
    .rtc_seconds (rtc_seconds),
    .btn         (btn),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item)
  );

  ctsc_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .setup_mode      (setup_mode),
    .blink           (blink),
    .display_update  (display_update),
    .display_seconds (display_seconds),
    .cursor_field    (cursor_field),
    .write_time      (write_time),
    .write_seconds   (write_seconds)
  );

endmodule
`default_nettype wire
